@@ hdl/ais_pkg.sv @@
// Package for the ascending insertion sorter: shared constants and types.
`default_nettype none
package ais_pkg;

  localparam int AIS_CAPACITY = 64;
  localparam int AIS_DATA_W   = 32;

  // One storage cell: occupancy flag and stored value
  typedef struct packed {
    logic                         valid;
    logic signed [AIS_DATA_W-1:0] value;
  } ais_cell_t;

  // Sorter control state
  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } ais_state_t;

endpackage
`default_nettype wire

@@ hdl/ais_cell.sv @@
// One cell of the insertion chain: holds one sorted entry, shifts right on insert, left on drain.
`default_nettype none
module ais_cell
  import ais_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         ins_en,
  input  wire logic                         shift_en,
  input  wire logic signed [AIS_DATA_W-1:0] new_value,
  input  wire ais_cell_t                    prev_cell,
  input  wire logic                         prev_gt,
  input  wire ais_cell_t                    next_cell,
  output      ais_cell_t                    cell_o,
  output      logic                         gt_o
);

  logic                         valid_r, valid_nxt;
  logic signed [AIS_DATA_W-1:0] value_r, value_nxt;

  // Empty cell counts as +inf so it always makes room
  assign gt_o = !valid_r || (value_r > new_value);

  // Insert: cells above the insertion point take the left neighbor, the boundary cell
  // takes the new value. Drain: every cell takes its right neighbor.
  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (shift_en) begin
      valid_nxt = next_cell.valid;
      value_nxt = next_cell.value;
    end else if (ins_en && gt_o) begin
      if (prev_gt) begin
        valid_nxt = prev_cell.valid;
        value_nxt = prev_cell.value;
      end else begin
        valid_nxt = 1'b1;
        value_nxt = new_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload carries no reset
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign cell_o.valid = valid_r;
  assign cell_o.value = value_r;

endmodule
`default_nettype wire

@@ hdl/ascending_insertion_sorter.sv @@
// Top level of the ascending insertion sorter: cell chain plus fill/drain control.
//
// Usage: values enter on the in_ channel (valid/stall), one per cycle, with in_last
// marking the final value of a run. Each accepted value is placed into a chain of
// CAPACITY cells that stays sorted ascending; all cells compare against the new value
// in parallel and take their new contents together. A value arriving while all
// CAPACITY cells are occupied is dropped and the run's overflow flag is set.
// When the last item is accepted (stored or dropped), the block switches to drain:
// in_stall goes high and the first result is valid in the next cycle. Results leave
// from the head cell on the out_ channel, smallest first, one per cycle while
// out_stall is low; the chain shifts toward the head on each accepted result.
// out_last_res marks the final result, out_overflow is set on every result of a run
// that dropped items. A run thus accepts every item (stored or dropped) on the input,
// then returns each stored value once on the output; after the final result the store
// and flag are empty and in_stall drops.
// While out_stall is high the head result holds and nothing moves.
// Reset (rst_n low, synchronous) empties all cells and returns to accepting input.
`default_nettype none
module ascending_insertion_sorter
  import ais_pkg::*;
#(
  parameter int CAPACITY = AIS_CAPACITY
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire logic signed [AIS_DATA_W-1:0] in_value,
  input  wire logic                         in_last,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      logic signed [AIS_DATA_W-1:0] out_value_res,
  output      logic                         out_last_res,
  output      logic                         out_overflow
);

  ais_state_t state_r, state_nxt;
  logic       drop_r, drop_nxt;

  ais_cell_t  cells [CAPACITY];
  logic       gt    [CAPACITY];

  logic in_acc, out_acc, full, ins_en, final_pop;

  assign full      = cells[CAPACITY-1].valid;
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign ins_en    = in_acc && !full;
  assign final_pop = out_acc && !cells[1].valid;

  // Cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ais_cell_t prev_c, next_c;
    logic      prev_g;
    if (i == 0) begin : g_head
      assign prev_c = '0;
      assign prev_g = 1'b0;
    end else begin : g_mid
      assign prev_c = cells[i-1];
      assign prev_g = gt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_c = '0;
    end else begin : g_body
      assign next_c = cells[i+1];
    end
    ais_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ins_en    (ins_en),
      .shift_en  (out_acc),
      .new_value (in_value),
      .prev_cell (prev_c),
      .prev_gt   (prev_g),
      .next_cell (next_c),
      .cell_o    (cells[i]),
      .gt_o      (gt[i])
    );
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_FILL:  if (in_acc && in_last) state_nxt = ST_DRAIN;
      ST_DRAIN: if (final_pop) state_nxt = ST_FILL;
      default:  state_nxt = ST_FILL;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_FILL:  in_stall  = 1'b0;
      ST_DRAIN: out_valid = 1'b1;
      default: begin
        in_stall  = 1'b1;
        out_valid = 1'b0;
      end
    endcase
  end

  // Overflow flag: set on a dropped item, cleared after the run's final result
  always_comb begin
    drop_nxt = drop_r;
    if (in_acc && full) begin
      drop_nxt = 1'b1;
    end else if (final_pop) begin
      drop_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      drop_r  <= drop_nxt;
    end
  end

  assign out_value_res = cells[0].value;
  assign out_last_res  = !cells[1].valid;
  assign out_overflow  = drop_r;

endmodule
`default_nettype wire
